// ===== rtl/core/hrbc_pkg.sv =====
// Package for the history ring with browse cursor.
// Holds sizes, operation codes, payload structs and index helpers.
// No dependencies.
`default_nettype none

package hrbc_pkg;

	// Ring geometry and payload size
	localparam int SLOTS         = 16;
	localparam int IDX_W         = $clog2(SLOTS);
	localparam int PAYLOAD_BYTES = 8;
	localparam int DATA_W        = 64;
	localparam int LEN_W         = 4;
	localparam int OP_W          = 2;

	// Operation codes; the unused code behaves as a forward walk
	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_BACK    = 2'd1;
	localparam logic [OP_W-1:0] OP_FWD     = 2'd2;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(PAYLOAD_BYTES);

	typedef logic [IDX_W-1:0] idx_t;

	// Input item
	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [DATA_W-1:0] entry_data;
		logic [LEN_W-1:0]  entry_length;
	} hrbc_in_t;

	// Result item
	typedef struct packed {
		logic [DATA_W-1:0] out_data;
		logic [LEN_W-1:0]  out_length;
	} hrbc_out_t;

	// Slot store write/clear controls
	typedef struct packed {
		logic              wr_en;
		idx_t              wr_idx;
		logic [DATA_W-1:0] wr_data;
		logic [LEN_W-1:0]  wr_length;
		logic              clr_en;
		idx_t              clr_idx;
	} hrbc_wr_t;

	function automatic idx_t wrap_next(input idx_t i);
		return (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t wrap_prev(input idx_t i);
		return (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
	endfunction

	// Keep the low len bytes, zero the rest
	function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			m[8*b +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hrbc_slots.sv =====
// Slot store of the history ring: data and length per slot, zeroed at reset.
// One write port, one clear port, one combinational read port.
// Depends on hrbc_pkg.
`default_nettype none

module hrbc_slots
	import hrbc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire hrbc_wr_t  ctl,
	input  wire idx_t      rd_idx,
	output hrbc_out_t      rd_entry
);

	logic [DATA_W-1:0] data_q   [SLOTS];
	logic [LEN_W-1:0]  length_q [SLOTS];

	// Write and clear never hit the same slot in one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				data_q[i]   <= '0;
				length_q[i] <= '0;
			end
		end else begin
			if (ctl.clr_en) begin
				data_q[ctl.clr_idx]   <= '0;
				length_q[ctl.clr_idx] <= '0;
			end
			if (ctl.wr_en) begin
				data_q[ctl.wr_idx]   <= ctl.wr_data;
				length_q[ctl.wr_idx] <= ctl.wr_length;
			end
		end
	end

	// Read at the cursor
	assign rd_entry.out_data   = data_q[rd_idx];
	assign rd_entry.out_length = length_q[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/core/history_ring_with_browse_cursor_core.sv =====
// Top level of the history ring with browse cursor.
// Depends on hrbc_pkg and hrbc_slots.
//
// Usage:
//  - Command channel: drive item and pulse start; the transfer happens at a
//    rising edge with start high and busy low. busy is always low, so one
//    command can be issued every cycle.
//  - Commands: enqueue (length 0 ignored, length above 8 saturated), walk
//    backward (always answers), walk forward (answers unless the next slot
//    is the write slot).
//  - Result channel: done is high for one cycle with the entry on result.
//    A command that answers reaches the ports through the input register,
//    then the result register, with no stall between them.
//  - Throughput: one command per cycle; each command writes at most one slot,
//    clears at most one slot and updates the three ring pointers in a single pass.
//  - Reset: all slots zeroed, head, tail and cursor at slot 0, no result.
//  - The receiver cannot stall; results are not held.
`default_nettype none

module history_ring_with_browse_cursor_core
	import hrbc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire hrbc_in_t item,
	output logic          done,
	output hrbc_out_t     result
);

	logic      valid_s1;
	hrbc_in_t  item_s1;
	idx_t      oldest_q, wr_q, cur_q;
	idx_t      oldest_d, wr_d, cur_d;
	logic      emit;
	hrbc_wr_t  slot_ctl;
	hrbc_out_t rd_entry;
	logic [LEN_W-1:0] len_sat;

	assign busy = 1'b0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			item_s1 <= item;
		end
	end

	assign len_sat = (item_s1.entry_length > LEN_MAX) ? LEN_MAX : item_s1.entry_length;

	// Pointer update and slot control for the registered command
	always_comb begin
		oldest_d          = oldest_q;
		wr_d              = wr_q;
		cur_d             = cur_q;
		emit              = 1'b0;
		slot_ctl.wr_en    = 1'b0;
		slot_ctl.wr_idx   = wr_q;
		slot_ctl.wr_data  = item_s1.entry_data & byte_mask(len_sat);
		slot_ctl.wr_length = len_sat;
		slot_ctl.clr_en   = 1'b0;
		slot_ctl.clr_idx  = oldest_q;
		if (valid_s1) begin
			case (item_s1.operation)
				OP_ENQUEUE: begin
					if (item_s1.entry_length != '0) begin
						// full ring: drop the oldest entry first
						if (wrap_next(wr_q) == oldest_q) begin
							slot_ctl.clr_en = 1'b1;
							oldest_d        = wrap_next(oldest_q);
						end
						slot_ctl.wr_en = 1'b1;
						cur_d          = wr_q;
						wr_d           = wrap_next(wr_q);
					end
				end
				OP_BACK: begin
					// steps back unless at head, where it stays; returns the entry either way
					if (cur_q != oldest_q) begin
						cur_d = wrap_prev(cur_q);
					end
					emit = 1'b1;
				end
				default: begin
					// forward walk; also the unused code
					if (wrap_next(cur_q) != wr_q) begin
						cur_d = wrap_next(cur_q);
						emit  = 1'b1;
					end
				end
			endcase
		end
	end

	hrbc_slots u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (slot_ctl),
		.rd_idx   (cur_d),
		.rd_entry (rd_entry)
	);

	// Ring pointers and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			wr_q     <= '0;
			cur_q    <= '0;
			done     <= 1'b0;
		end else begin
			oldest_q <= oldest_d;
			wr_q     <= wr_d;
			cur_q    <= cur_d;
			done     <= emit;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (emit) begin
			result <= rd_entry;
		end
	end

endmodule

`default_nettype wire

// ===== test/hrbc_checker.sv =====
// Checker for the history ring with browse cursor: watches the command and result channels.
// Keeps its own copy of the ring, predicts each walk result and compares field by field.
// Depends on hrbc_pkg.

module hrbc_checker
	import hrbc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire logic      busy,
	input  wire hrbc_in_t  item,
	input  wire logic      done,
	input  wire hrbc_out_t result,
	output int             errors,
	output int             pending,
	output int             compared
);

	// Shadow ring: payloads, lengths and the three pointers
	logic [DATA_W-1:0] ring_data [SLOTS];
	logic [LEN_W-1:0]  ring_len  [SLOTS];
	idx_t              head_idx;
	idx_t              tail_idx;
	idx_t              cursor_idx;
	hrbc_out_t         expected_entries [$];

	function automatic idx_t ring_succ(input idx_t i);
		return (i == idx_t'(SLOTS - 1)) ? '0 : idx_t'(i + 1);
	endfunction

	function automatic idx_t ring_pred(input idx_t i);
		return (i == '0) ? idx_t'(SLOTS - 1) : idx_t'(i - 1);
	endfunction

	// Bytes above the item length are stored as zero
	function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] d,
			input logic [LEN_W-1:0] n);
		logic [DATA_W-1:0] r;
		r = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			if (b < int'(n))
				r[8*b +: 8] = d[8*b +: 8];
		end
		return r;
	endfunction

	// Apply one command to the shadow ring; returns 1 when the block answers
	function automatic bit predict_command(input hrbc_in_t cmd, output hrbc_out_t reply);
		logic [LEN_W-1:0] n;
		idx_t             step;
		reply = '0;
		n = cmd.entry_length;
		case (cmd.operation)
			OP_ENQUEUE: begin
				if (n == '0)
					return 0;
				if (n > LEN_MAX)
					n = LEN_MAX;
				// full ring: drop the oldest entry first
				if (ring_succ(tail_idx) == head_idx && ring_len[head_idx] != '0) begin
					ring_data[head_idx] = '0;
					ring_len[head_idx]  = '0;
					head_idx = ring_succ(head_idx);
				end
				cursor_idx = tail_idx;
				ring_data[tail_idx] = keep_bytes(cmd.entry_data, n);
				ring_len[tail_idx]  = n;
				tail_idx = ring_succ(tail_idx);
				return 0;
			end
			OP_BACK: begin
				// stops at the oldest entry
				if (cursor_idx != head_idx)
					cursor_idx = ring_pred(cursor_idx);
			end
			default: begin
				// forward walk; the spare code behaves the same
				step = ring_succ(cursor_idx);
				if (step == tail_idx)
					return 0;
				cursor_idx = step;
			end
		endcase
		reply.out_data   = ring_data[cursor_idx];
		reply.out_length = ring_len[cursor_idx];
		return 1;
	endfunction

	// Result side first, then the command transfer of the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		hrbc_out_t reply;
		hrbc_out_t want;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				ring_data[s] = '0;
				ring_len[s]  = '0;
			end
			head_idx   = '0;
			tail_idx   = '0;
			cursor_idx = '0;
			expected_entries.delete();
			errors   = 0;
			compared = 0;
		end else begin
			if (done) begin
				if (expected_entries.size() == 0) begin
					errors++;
					$error("unexpected result: out_data %h out_length %0d",
						result.out_data, result.out_length);
				end else begin
					want = expected_entries.pop_front();
					compared++;
					if (result.out_data !== want.out_data) begin
						errors++;
						$error("out_data: expected %h, got %h", want.out_data, result.out_data);
					end
					if (result.out_length !== want.out_length) begin
						errors++;
						$error("out_length: expected %0d, got %0d",
							want.out_length, result.out_length);
					end
				end
			end
			if (start && !busy) begin
				if (predict_command(item, reply))
					expected_entries.push_back(reply);
			end
		end
		pending = expected_entries.size();
	end

endmodule

// ===== test/testbench.sv =====
// Top of the testbench for history_ring_with_browse_cursor_core: clock, reset and command stimulus.
// Directed corner cases first, then random enqueue bursts and walks; hrbc_checker does the checking.
// Depends on hrbc_pkg, hrbc_checker and the core.

module testbench;
	import hrbc_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_COMMANDS = 1300;
	localparam int CALM_TAIL       = 200;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	hrbc_in_t  item   = '0;
	logic      busy;
	logic      done;
	hrbc_out_t result;
	int        errors;
	int        pending;
	int        compared;
	int        issued = 0;
	bit        calm   = 1'b0;
	bit        drained_once = 1'b0;

	history_ring_with_browse_cursor_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	hrbc_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.errors   (errors),
		.pending  (pending),
		.compared (compared)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#(12 * 300000);
		$display("status: fail");
		$finish;
	end

	function automatic hrbc_in_t make_cmd(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] d, input logic [LEN_W-1:0] n);
		hrbc_in_t c;
		c.operation    = op;
		c.entry_data   = d;
		c.entry_length = n;
		return c;
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Mostly legal lengths, some zero, some over-long
	function automatic logic [LEN_W-1:0] rand_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return '0;
		if (r < 4)
			return LEN_W'($urandom_range(PAYLOAD_BYTES + 1, 15));
		return LEN_W'($urandom_range(1, PAYLOAD_BYTES));
	endfunction

	// One command transfer; busy is sampled mid-cycle where it is stable
	task automatic issue(input hrbc_in_t cmd);
		bit stalled;
		start <= 1'b1;
		item  <= cmd;
		do begin
			@(negedge clk);
			stalled = busy;
			@(posedge clk);
		end while (stalled);
		if (!(cmd.operation == OP_ENQUEUE && cmd.entry_length == '0))
			issued++;
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		item  <= make_cmd(OP_W'($urandom_range(0, 3)), rand_word(), rand_len());
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(0, 3) == 0)
			pause($urandom_range(1, 5));
	endtask

	// Hold off until every predicted result has come back
	task automatic drain(input int settle);
		int guard;
		guard = 0;
		start <= 1'b0;
		do begin
			@(negedge clk);
			guard++;
		end while (pending != 0 && guard < 400);
		repeat (settle) @(posedge clk);
	endtask

	// Random episode: enqueue burst, backward run, forward run or a mix
	task automatic run_episode();
		int               kind;
		int               count;
		int               r;
		logic [OP_W-1:0]  op;
		kind  = $urandom_range(0, 9);
		count = $urandom_range(1, 20);
		calm  = (issued > RANDOM_COMMANDS - CALM_TAIL) || ($urandom_range(0, 4) == 0);
		repeat (count) begin
			maybe_pause();
			r = $urandom_range(0, 19);
			if (kind < 3)
				op = OP_ENQUEUE;
			else if (kind < 5)
				op = OP_BACK;
			else if (kind < 7)
				op = (r == 0) ? OP_SPARE : OP_FWD;
			else if (r < 8)
				op = OP_ENQUEUE;
			else if (r < 13)
				op = OP_BACK;
			else if (r < 19)
				op = OP_FWD;
			else
				op = OP_SPARE;
			issue(make_cmd(op, rand_word(), rand_len()));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Walks on the empty ring
		issue(make_cmd(OP_BACK, '0, '0));
		issue(make_cmd(OP_FWD, '0, '0));
		issue(make_cmd(OP_BACK, '1, '1));
		// Enqueue corners: ignored, saturated, shortest, full width, masked bytes
		issue(make_cmd(OP_ENQUEUE, '1, '0));
		issue(make_cmd(OP_ENQUEUE, '1, 4'd15));
		issue(make_cmd(OP_ENQUEUE, '1, 4'd1));
		issue(make_cmd(OP_ENQUEUE, 64'h0123_4567_89ab_cdef, LEN_MAX));
		issue(make_cmd(OP_ENQUEUE, 64'hfedc_ba98_7654_3210, 4'd9));
		issue(make_cmd(OP_ENQUEUE, '0, 4'd4));
		issue(make_cmd(OP_ENQUEUE, '1, 4'd7));
		// Back to the oldest entry, then two more that stay there
		repeat (7) issue(make_cmd(OP_BACK, rand_word(), rand_len()));
		// Forward to the newest, then a forward and a spare-code walk that give nothing
		repeat (6) issue(make_cmd(OP_FWD, rand_word(), rand_len()));
		issue(make_cmd(OP_SPARE, '1, '1));
		// One back from the newest, then forward to it again
		issue(make_cmd(OP_BACK, '0, '0));
		issue(make_cmd(OP_FWD, '0, '0));

		issued = 0;
		while (issued < RANDOM_COMMANDS) begin
			run_episode();
			if (!drained_once && issued > RANDOM_COMMANDS / 2) begin
				drain(4);
				drained_once = 1'b1;
			end
		end

		drain(8);
		@(negedge clk);
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		$display("covered %0d random commands after the directed set:", issued);
		$display("  enqueues with wrap and overwrite, walks both ways; %0d results compared",
			compared);
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
